// ===== sv/tcd_pkg.sv =====
`default_nettype none
package tcd_pkg;

  localparam int unsigned CHAR_W = 7;

  localparam logic [3:0] EOP_CODE = 4'd8;
  localparam logic [3:0] ONE_BASE = 4'd10;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [1:0] ST_CHAR   = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic ADDR_TIMEOUT = 1'b0;

  typedef struct packed {
    logic        tone_present;
    logic [3:0]  tone_code;
    logic [31:0] time_ms;
  } tcd_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [CHAR_W-1:0] character;
    logic              last;
  } tcd_out_t;

  function automatic logic tcd_allowed(input logic [CHAR_W-1:0] c);
    logic ok;
    ok = c inside {[7'd48:7'd57], [7'd65:7'd90], [7'd97:7'd122],
                   7'd123, 7'd125, 7'd91, 7'd93, 7'd40, 7'd41, 7'd58, 7'd59};
    return ok;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tcd_char_mem.sv =====
`default_nettype none
module tcd_char_mem #(
  parameter int unsigned DEPTH = 63,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [tcd_pkg::CHAR_W-1:0] wdata_i,
  input  wire logic [AW-1:0]              raddr_i,
  output logic      [tcd_pkg::CHAR_W-1:0] rdata_o
);
  import tcd_pkg::*;

  logic [CHAR_W-1:0] mem_q [DEPTH];
  logic [CHAR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/tone_code_run_length_char_deframer.sv =====
`default_nettype none
// Tone sample beat: accepted when idle; a run code then shifts its bits
// into the character store one bit per cycle, 2^(code mod 10) bits (up to 512).
// Flush: each emitted character goes through store read, output load and handoff,
// and waits out any output stall; markers skip the load. Input is held off meanwhile.
// Reset clears all control state; the store needs no clearing, as only characters
// below the fill count are ever read.
module tone_code_run_length_char_deframer #(
  parameter int unsigned CHAR_CAPACITY = 63
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire tcd_pkg::tcd_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output tcd_pkg::tcd_out_t      out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);
  import tcd_pkg::*;

  localparam int unsigned CW = $clog2(CHAR_CAPACITY + 1);
  localparam int unsigned AW = (CHAR_CAPACITY > 1) ? $clog2(CHAR_CAPACITY) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_APPEND = 5'b00010,
    S_FLUSH  = 5'b00100,
    S_LOAD   = 5'b01000,
    S_WAIT   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic              silence_q, silence_d;
  logic              armed_q, armed_d;
  logic [31:0]       last_time_q, last_time_d;
  logic [15:0]       timeout_q;
  logic [9:0]        run_left_q, run_left_d;
  logic              run_bit_q, run_bit_d;
  logic [CHAR_W-1:0] asm_q, asm_d;
  logic [2:0]        bitpos_q, bitpos_d;
  logic [CW-1:0]     char_cnt_q, char_cnt_d;
  logic              stop_q, stop_d;
  logic              bad_q, bad_d;
  logic [CW-1:0]     emit_idx_q, emit_idx_d;
  logic              out_valid_q, out_valid_d;
  tcd_out_t          out_q, out_d;

  logic              mem_we;
  logic [CHAR_W-1:0] asm_next;
  logic [CHAR_W-1:0] rd_data;
  logic [31:0]       elapsed;
  logic [3:0]        code_mod;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_TIMEOUT);
  assign prdata = (paddr[2] == ADDR_TIMEOUT) ? {16'd0, timeout_q} : 32'd0;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign asm_next = {asm_q[CHAR_W-2:0], run_bit_q};
  assign elapsed  = in_data_i.time_ms - last_time_q;
  assign code_mod = (in_data_i.tone_code >= ONE_BASE) ? (in_data_i.tone_code - ONE_BASE)
                                                      : in_data_i.tone_code;

  tcd_char_mem #(
    .DEPTH (CHAR_CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (char_cnt_q[AW-1:0]),
    .wdata_i (asm_next),
    .raddr_i (emit_idx_q[AW-1:0]),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    silence_d   = silence_q;
    armed_d     = armed_q;
    last_time_d = last_time_q;
    run_left_d  = run_left_q;
    run_bit_d   = run_bit_q;
    asm_d       = asm_q;
    bitpos_d    = bitpos_q;
    char_cnt_d  = char_cnt_q;
    stop_d      = stop_q;
    bad_d       = bad_q;
    emit_idx_d  = emit_idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!in_data_i.tone_present) begin
            silence_d = 1'b1;
            if (armed_q && (elapsed >= {16'd0, timeout_q})) begin
              armed_d = 1'b0;
              state_d = S_FLUSH;
            end
          end else if (silence_q) begin
            silence_d = 1'b0;
            if (in_data_i.tone_code == EOP_CODE) begin
              armed_d = 1'b0;
              state_d = S_FLUSH;
            end else begin
              armed_d     = 1'b1;
              last_time_d = in_data_i.time_ms;
              run_left_d  = 10'd1 << code_mod;
              run_bit_d   = (in_data_i.tone_code >= ONE_BASE);
              state_d     = S_APPEND;
            end
          end
        end
      end
      S_APPEND: begin
        asm_d      = asm_next;
        run_left_d = run_left_q - 10'd1;
        if (run_left_q == 10'd1) begin
          state_d = S_IDLE;
        end
        if (bitpos_q == 3'(CHAR_W - 1)) begin
          mem_we     = 1'b1;
          bitpos_d   = 3'd0;
          char_cnt_d = char_cnt_q + 1'b1;
          if (!stop_q) begin
            if (asm_next == '0) begin
              stop_d = 1'b1;
            end else if (!tcd_allowed(asm_next)) begin
              bad_d = 1'b1;
            end
          end
          if (char_cnt_q == CW'(CHAR_CAPACITY - 1)) begin
            state_d = S_FLUSH;
          end
        end else begin
          bitpos_d = bitpos_q + 3'd1;
        end
      end
      S_FLUSH: begin
        if (bad_q) begin
          out_d       = '{status: ST_REJECT, character: '0, last: 1'b1};
          out_valid_d = 1'b1;
          state_d     = S_WAIT;
        end else if (char_cnt_q == '0) begin
          out_d       = '{status: ST_EMPTY, character: '0, last: 1'b1};
          out_valid_d = 1'b1;
          state_d     = S_WAIT;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        out_d       = '{status: ST_CHAR, character: rd_data,
                        last: (CW'(emit_idx_q + 1'b1) == char_cnt_q)};
        out_valid_d = 1'b1;
        state_d     = S_WAIT;
      end
      S_WAIT: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_q.last) begin
            char_cnt_d = '0;
            bitpos_d   = 3'd0;
            stop_d     = 1'b0;
            bad_d      = 1'b0;
            emit_idx_d = '0;
            state_d    = S_IDLE;
          end else begin
            emit_idx_d = emit_idx_q + 1'b1;
            state_d    = S_FLUSH;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      silence_q   <= 1'b0;
      armed_q     <= 1'b0;
      last_time_q <= '0;
      timeout_q   <= TIMEOUT_RESET;
      run_left_q  <= '0;
      bitpos_q    <= '0;
      char_cnt_q  <= '0;
      stop_q      <= 1'b0;
      bad_q       <= 1'b0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      silence_q   <= silence_d;
      armed_q     <= armed_d;
      last_time_q <= last_time_d;
      run_left_q  <= run_left_d;
      bitpos_q    <= bitpos_d;
      char_cnt_q  <= char_cnt_d;
      stop_q      <= stop_d;
      bad_q       <= bad_d;
      emit_idx_q  <= emit_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        timeout_q <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    run_bit_q <= run_bit_d;
    asm_q     <= asm_d;
    out_q     <= out_d;
  end

  a_out_only_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_WAIT))
    else $error("result beat outside handoff state");

  a_no_input_during_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input taken while result pending");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_cnt_q <= CW'(CHAR_CAPACITY))
    else $error("character count beyond capacity");

  a_marker_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ST_CHAR)) |-> out_data_o.last)
    else $error("marker beat without last");

  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPEND) |-> (run_left_q != 10'd0))
    else $error("append with empty run");

  a_bit_emit_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(emit_idx_q) && out_valid_o))
    else $error("emit index moved while stalled");

endmodule
`default_nettype wire

// ===== test/tcd_checker.sv =====
module tcd_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  tcd_pkg::tcd_in_t   in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  tcd_pkg::tcd_out_t  out_data_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [2:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic [31:0]        prdata_i,
  input  logic               pready_i,
  output int                 errors_o,
  output int                 pending_o
);
  import tcd_pkg::*;

  localparam int STORE_BITS = 63 * CHAR_W;

  logic [STORE_BITS-1:0] bit_store;
  int                    bit_count;
  bit                    heard_silence;
  bit                    armed;
  logic [31:0]           last_code_ms;
  logic [15:0]           tmo_limit;
  tcd_out_t              due_q[$];

  function automatic bit legal_char(input logic [CHAR_W-1:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           c == "{" || c == "}" || c == "[" || c == "]" ||
           c == "(" || c == ")" || c == ":" || c == ";";
  endfunction

  task automatic push_result(input logic [1:0] st, input logic [CHAR_W-1:0] ch,
                             input logic last);
    tcd_out_t r;
    r.status    = st;
    r.character = ch;
    r.last      = last;
    due_q.push_back(r);
  endtask

  task automatic flush_store();
    logic [CHAR_W-1:0] chars [0:62];
    int n;
    bit ok;
    bit stop;
    n = bit_count / CHAR_W;
    if (n > 63) n = 63;
    for (int i = 0; i < n; i++) begin
      chars[i] = '0;
      for (int j = 0; j < CHAR_W; j++)
        chars[i] = {chars[i][CHAR_W-2:0], bit_store[i*CHAR_W+j]};
    end
    ok = 1'b1;
    stop = 1'b0;
    for (int i = 0; i < n && !stop; i++) begin
      if (chars[i] == '0) stop = 1'b1;
      else if (!legal_char(chars[i])) ok = 1'b0;
    end
    if (!ok) begin
      push_result(ST_REJECT, '0, 1'b1);
    end else if (n == 0) begin
      push_result(ST_EMPTY, '0, 1'b1);
    end else begin
      for (int i = 0; i < n; i++) push_result(ST_CHAR, chars[i], i + 1 == n);
    end
    bit_store = '0;
    bit_count = 0;
  endtask

  task automatic take_sample(input tcd_in_t s);
    logic [31:0] elapsed;
    int run;
    int i;
    bit fill;
    bit full;
    if (!s.tone_present) begin
      heard_silence = 1'b1;
      elapsed = s.time_ms - last_code_ms;
      if (armed && elapsed >= {16'h0, tmo_limit}) begin
        armed = 1'b0;
        flush_store();
      end
    end else if (heard_silence) begin
      heard_silence = 1'b0;
      if (s.tone_code == EOP_CODE) begin
        armed = 1'b0;
        flush_store();
      end else begin
        armed = 1'b1;
        last_code_ms = s.time_ms;
        run = 1 << (s.tone_code % 10);
        fill = s.tone_code >= ONE_BASE;
        i = 0;
        full = 1'b0;
        while (i < run && !full) begin
          bit_store[bit_count] = fill;
          bit_count++;
          i++;
          if (bit_count >= STORE_BITS) begin
            flush_store();
            full = 1'b1;
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tcd_out_t want;
    if (!rst_ni) begin
      bit_store = '0;
      bit_count = 0;
      heard_silence = 1'b0;
      armed = 1'b0;
      last_code_ms = '0;
      tmo_limit = TIMEOUT_RESET;
      due_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i == {ADDR_TIMEOUT, 2'b00}) begin
        if (pwrite_i) begin
          tmo_limit = pwdata_i[15:0];
        end else if (prdata_i[15:0] !== tmo_limit) begin
          $display("%0t: timeout readback: expected %0d, got %0d", $time, tmo_limit,
                   prdata_i[15:0]);
          errors_o++;
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (due_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, got status %0d char 'h%02h last %0d",
                   $time, out_data_i.status, out_data_i.character, out_data_i.last);
          errors_o++;
        end else begin
          want = due_q.pop_front();
          if (out_data_i.status !== want.status || out_data_i.character !== want.character ||
              out_data_i.last !== want.last) begin
            $display("%0t: mismatch: expected status %0d char 'h%02h last %0d, %s %0d %s 'h%02h %s %0d",
                     $time, want.status, want.character, want.last,
                     "got status", out_data_i.status, "char", out_data_i.character,
                     "last", out_data_i.last);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) take_sample(in_data_i);
      pending_o = due_q.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  import tcd_pkg::*;

  typedef enum {END_EOP, END_TIMEOUT, END_OPEN} pk_end_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  tcd_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  tcd_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;

  logic [31:0] now_ms;
  logic [15:0] cur_timeout;
  bit          calm;
  bit          hold_req;
  bit          after_quiet;
  int          live_items;
  logic [0:127] pk_bits;
  int          pk_len;
  string       legal_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz{}[]():;";
  string       odd_set = "!\"#$%&'*+,-./<=>?@\\^_`|~";

  tone_code_run_length_char_deframer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  tcd_checker i_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .pready_i    (pready),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("tb: failure");
    $finish;
  end

  // receiver: random per-beat stalls, one long hold-off on request
  initial begin
    int pause;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pause = 1500;
      end else begin
        pause = calm ? 0 : $urandom_range(0, 5);
      end
      if (pause > 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && !hold_req);
    end
  end

  function automatic int small_step();
    int lim;
    lim = (cur_timeout > 41) ? 40 : cur_timeout - 1;
    return $urandom_range(0, lim);
  endfunction

  task automatic put_sample(input logic present, input logic [3:0] code);
    tcd_in_t d;
    int gap;
    d.tone_present = present;
    d.tone_code = code;
    d.time_ms = now_ms;
    if (!present || after_quiet) live_items++;
    after_quiet = !present;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic quiet(input int unsigned delta);
    now_ms = now_ms + delta;
    put_sample(1'b0, 4'($urandom_range(0, 15)));
  endtask

  task automatic tone(input logic [3:0] code);
    put_sample(1'b1, code);
  endtask

  task automatic add_char(input logic [6:0] c);
    for (int j = 6; j >= 0; j--) begin
      pk_bits[pk_len] = c[j];
      pk_len++;
    end
  endtask

  // split the bit string into runs of 1, 2 or 4 equal bits
  task automatic send_bits();
    int pos;
    int run;
    int sel;
    logic b;
    pos = 0;
    while (pos < pk_len) begin
      b = pk_bits[pos];
      run = 1;
      while (run < 4 && pos + run < pk_len && pk_bits[pos+run] == b) run++;
      sel = (run == 4) ? $urandom_range(0, 2) : (run >= 2) ? $urandom_range(0, 1) : 0;
      quiet(small_step());
      tone((b ? ONE_BASE : 4'd0) + 4'(sel));
      pos += 1 << sel;
    end
  endtask

  task automatic send_packet(input int n, input pk_end_e how);
    int r;
    logic [6:0] c;
    pk_len = 0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 84) c = 7'(legal_set[$urandom_range(0, legal_set.len() - 1)]);
      else if (r < 88) c = 7'(odd_set[$urandom_range(0, odd_set.len() - 1)]);
      else if (r < 92) c = $urandom_range(0, 1) ? 7'h7F : 7'($urandom_range(1, 31));
      else c = '0;
      add_char(c);
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        pk_bits[pk_len] = 1'($urandom_range(0, 1));
        pk_len++;
      end
    end
    send_bits();
    case (how)
      END_EOP: begin
        quiet(small_step());
        tone(EOP_CODE);
      end
      END_TIMEOUT: begin
        if ($urandom_range(0, 2) == 0) begin
          quiet(cur_timeout - 1);
          quiet(1);
        end else begin
          quiet(cur_timeout + $urandom_range(0, 3));
        end
      end
      default: ;
    endcase
  endtask

  task automatic run_until(input int goal);
    int r;
    while (live_items < goal) begin
      calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        send_packet(($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5),
                    ($urandom_range(0, 4) < 3) ? END_EOP : END_TIMEOUT);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 3) == 0) now_ms = $urandom;
          else now_ms = now_ms + small_step();
          put_sample(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        end
      end
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (600) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {ADDR_TIMEOUT, 2'b00};
    pwdata <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_timeout(input logic [15:0] val);
    apb_access(1'b1, val);
    cur_timeout = val;
    apb_access(1'b0, 16'h0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 1'b0;
    calm = 1'b0;
    after_quiet = 1'b0;
    live_items = 0;
    cur_timeout = TIMEOUT_RESET;
    now_ms = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // first tone after reset and a tone without silence are dropped; 4 bits give an empty packet
    tone(ONE_BASE);
    quiet(0);
    tone(ONE_BASE + 4'd2);
    tone(ONE_BASE + 4'd1);
    quiet(3);
    tone(EOP_CODE);
    // 'z' across the time wrap, flushed exactly at the timeout
    now_ms = 32'hFFFF_FFFE;
    quiet(1);
    tone(ONE_BASE + 4'd2);
    quiet(1);
    tone(4'd0);
    quiet(0);
    tone(ONE_BASE);
    quiet(0);
    tone(4'd0);
    quiet(998);
    quiet(2);
    // rejected packet
    pk_len = 0;
    add_char(7'h01);
    send_bits();
    quiet(1);
    tone(EOP_CODE);
    // store overflow
    quiet(0);
    tone(4'd9);
    settle();

    apb_access(1'b0, 16'h0);
    set_timeout(16'd1);
    run_until(130);
    settle();

    set_timeout(16'hFFFF);
    calm = 1'b1;
    send_packet(10, END_OPEN);
    hold_req = 1'b1;
    quiet(small_step());
    tone(EOP_CODE);
    send_packet(6, END_EOP);
    run_until(250);
    settle();

    set_timeout(16'($urandom_range(2, 300)));
    run_until(360);
    settle();

    set_timeout(16'($urandom_range(1, 65535)));
    run_until(460);
    settle();

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
